// ===== hw/rtl/cevs_pkg.sv =====
// cevs_pkg: shared types and constants for the checkpoint eviction victim selector
// no dependencies; imported by every module of the block
`default_nettype none

package cevs_pkg;

    localparam int TOKEN_W = 32;
    localparam int ORD_W   = 16;
    localparam int SPAN_W  = 34;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 3;

    localparam int DEF_QUEUE_DEPTH = 2;

    // protection classes
    localparam logic [1:0] PROT_FREE   = 2'd0;
    localparam logic [1:0] PROT_ANCHOR = 2'd1;
    localparam logic [1:0] PROT_LEASE  = 2'd2;
    localparam logic [1:0] PROT_SEAM   = 2'd3;

    // result reason codes
    localparam logic [1:0] REASON_SELECTED = 2'd0;
    localparam logic [1:0] REASON_LEASE    = 2'd1;
    localparam logic [1:0] REASON_NONE     = 2'd2;

    // span scores of the list ends
    localparam logic [SPAN_W-1:0] SPAN_FIRST = {SPAN_W{1'b1}};
    localparam logic [SPAN_W-1:0] SPAN_LAST  = {{(SPAN_W-1){1'b1}}, 1'b0};

    typedef logic [TOKEN_W-1:0] t_token;
    typedef logic [ORD_W-1:0]   t_ord;
    typedef logic [SPAN_W-1:0]  t_span;

    // one classified descriptor as it waits in the queue
    typedef struct packed {
        t_token tok;
        t_ord   ord;
        logic   is_free;
        logic   is_seam;
        logic   is_lease;
        logic   order_bad;
        logic   last;
    } t_item_rec;

endpackage

`default_nettype wire

// ===== hw/rtl/checkpoint_eviction_victim_select_top.sv =====
// the verdict for a list passes through the queue and then the result register after the edge that accepts tlast
// throughput: one descriptor per cycle while the queue is not full, set by the back end's span subtract and compare
// the result register lets non-final descriptors keep flowing while a verdict waits on
// i_m_tready; the next tlast descriptor then waits in the queue and can stall the input
// reset: synchronous active-low i_rst_n empties the queue, drops o_m_tvalid and
// returns the selector to the start-of-list state
`default_nettype none

// checkpoint eviction victim selector, top level
// depends on cevs_pkg, cevs_front, cevs_queue, cevs_back
module checkpoint_eviction_victim_select_top #(
    parameter int P_QUEUE_DEPTH = cevs_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // descriptor stream
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // [31:0] token_count, [47:32] entry_ordinal
    input  wire logic [cevs_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [0] pinned, [2:1] protection
    input  wire logic [cevs_pkg::S_TUSER_W-1:0] i_s_tuser,
    input  wire logic                           i_s_tlast,
    // verdict stream
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // [15:0] victim_ordinal
    output logic [cevs_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // [0] victim_found, [2:1] reason
    output logic [cevs_pkg::M_TUSER_W-1:0]      o_m_tuser
);
    import cevs_pkg::*;

    // front to queue
    logic       push;
    t_item_rec  front_rec;
    logic       q_full;

    // queue to back end
    logic       q_valid;
    t_item_rec  q_rec;
    logic       pop;

    // front end: classify each descriptor and flag token order breaks
    cevs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_tok    (i_s_tdata[TOKEN_W-1:0]),
        .i_ord    (i_s_tdata[TOKEN_W+ORD_W-1:TOKEN_W]),
        .i_pinned (i_s_tuser[0]),
        .i_prot   (i_s_tuser[2:1]),
        .i_last   (i_s_tlast),
        .i_q_full (q_full),
        .o_ready  (o_s_tready),
        .o_push   (push),
        .o_rec    (front_rec)
    );

    // decoupling queue
    cevs_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rec   (q_rec)
    );

    // back end: one-item-late span scoring and final pick
    cevs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (q_valid),
        .i_rec       (q_rec),
        .o_pop       (pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/cevs_front.sv =====
// cevs_front: accepts descriptor beats, classifies them and checks token order
// depends on cevs_pkg; feeds cevs_queue
`default_nettype none

module cevs_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire cevs_pkg::t_token           i_tok,
    input  wire cevs_pkg::t_ord             i_ord,
    input  wire logic                       i_pinned,
    input  wire logic [1:0]                 i_prot,
    input  wire logic                       i_last,
    input  wire logic                       i_q_full,
    output logic                            o_ready,
    output logic                            o_push,
    output cevs_pkg::t_item_rec             o_rec
);
    import cevs_pkg::*;

    logic   r_first;
    logic   n_first;
    t_token r_prior_tok;
    t_token n_prior_tok;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_rec.tok       = i_tok;
        o_rec.ord       = i_ord;
        o_rec.is_free   = !i_pinned && (i_prot == PROT_FREE);
        o_rec.is_seam   = !i_pinned && (i_prot == PROT_SEAM);
        // a hard lease blocks even when pinned
        o_rec.is_lease  = (i_prot == PROT_LEASE);
        o_rec.order_bad = r_first ? (i_tok == '0) : (i_tok <= r_prior_tok);
        o_rec.last      = i_last;
    end

    always_comb begin
        n_first     = r_first;
        n_prior_tok = r_prior_tok;
        if (o_push) begin
            n_first     = i_last;
            n_prior_tok = i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else begin
            r_first <= n_first;
        end
        r_prior_tok <= n_prior_tok;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cevs_queue.sv =====
// cevs_queue: short fifo of classified descriptors between front and back end
// depends on cevs_pkg
`default_nettype none

module cevs_queue #(
    parameter int P_DEPTH = cevs_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire cevs_pkg::t_item_rec        i_rec,
    input  wire logic                       i_pop,
    output logic                            o_full,
    output logic                            o_valid,
    output cevs_pkg::t_item_rec             o_rec
);
    import cevs_pkg::*;

    localparam int PTR_W = $clog2(P_DEPTH);
    localparam int CNT_W = $clog2(P_DEPTH + 1);

    t_item_rec          r_mem [P_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(P_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cevs_back.sv =====
// cevs_back: scores free entries by merged span, tracks fallbacks and emits the verdict
// depends on cevs_pkg; drains cevs_queue and owns the result register
`default_nettype none

module cevs_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_rec_valid,
    input  wire cevs_pkg::t_item_rec        i_rec,
    output logic                            o_pop,
    output logic                            o_m_tvalid,
    input  wire logic                       i_m_tready,
    output logic [cevs_pkg::M_TDATA_W-1:0]  o_m_tdata,
    output logic [cevs_pkg::M_TUSER_W-1:0]  o_m_tuser
);
    import cevs_pkg::*;

    logic   r_first,        n_first;
    t_token r_prior_tok,    n_prior_tok;
    t_token r_prior2_tok,   n_prior2_tok;
    logic   r_pend_free,    n_pend_free;
    t_ord   r_pend_ord,     n_pend_ord;
    logic   r_pend_start,   n_pend_start;
    logic   r_order_ok,     n_order_ok;
    logic   r_ff_seen,      n_ff_seen;
    t_ord   r_ff_ord,       n_ff_ord;
    logic   r_best_seen,    n_best_seen;
    t_span  r_min_span,     n_min_span;
    t_ord   r_best_ord,     n_best_ord;
    logic   r_fb_seen,      n_fb_seen;
    t_ord   r_fb_ord,       n_fb_ord;
    logic   r_lease,        n_lease;

    logic                   r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0]   r_out_data,  n_out_data;
    logic [M_TUSER_W-1:0]   r_out_user,  n_out_user;

    t_span      span_pend;
    logic       found;
    t_ord       pick;
    logic [1:0] reason;

    // a non-final item never needs the result register
    assign o_pop      = i_rec_valid && (!i_rec.last || !r_out_valid || i_m_tready);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    always_comb begin
        n_first      = r_first;
        n_prior_tok  = r_prior_tok;
        n_prior2_tok = r_prior2_tok;
        n_pend_free  = r_pend_free;
        n_pend_ord   = r_pend_ord;
        n_pend_start = r_pend_start;
        n_order_ok   = r_order_ok;
        n_ff_seen    = r_ff_seen;
        n_ff_ord     = r_ff_ord;
        n_best_seen  = r_best_seen;
        n_min_span   = r_min_span;
        n_best_ord   = r_best_ord;
        n_fb_seen    = r_fb_seen;
        n_fb_ord     = r_fb_ord;
        n_lease      = r_lease;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_data   = r_out_data;
        n_out_user   = r_out_user;
        found        = 1'b0;
        pick         = '0;
        reason       = REASON_NONE;

        span_pend = r_pend_start ? SPAN_FIRST
                                 : {{(SPAN_W-TOKEN_W){1'b0}}, i_rec.tok - r_prior2_tok};

        if (o_pop) begin
            // held-back entry now has its right neighbor
            if (r_pend_free && (!r_best_seen || span_pend < r_min_span)) begin
                n_best_seen = 1'b1;
                n_min_span  = span_pend;
                n_best_ord  = r_pend_ord;
            end

            n_order_ok = r_order_ok && !i_rec.order_bad;

            if (i_rec.is_lease) begin
                n_lease = 1'b1;
            end
            if (i_rec.is_seam && !r_fb_seen) begin
                n_fb_seen = 1'b1;
                n_fb_ord  = i_rec.ord;
            end
            if (i_rec.is_free && !r_ff_seen) begin
                n_ff_seen = 1'b1;
                n_ff_ord  = i_rec.ord;
            end

            if (!i_rec.last) begin
                n_prior2_tok = r_prior_tok;
                n_prior_tok  = i_rec.tok;
                n_pend_free  = i_rec.is_free;
                n_pend_ord   = i_rec.ord;
                n_pend_start = r_first;
                n_first      = 1'b0;
            end else begin
                // free final entry scores just below a first entry
                if (i_rec.is_free && (!n_best_seen || n_min_span == SPAN_FIRST)) begin
                    n_best_seen = 1'b1;
                    n_best_ord  = i_rec.ord;
                end

                priority if (n_order_ok && n_best_seen) begin
                    found = 1'b1;
                    pick  = n_best_ord;
                end else if (!n_order_ok && n_ff_seen) begin
                    found = 1'b1;
                    pick  = n_ff_ord;
                end else if (n_fb_seen) begin
                    found = 1'b1;
                    pick  = n_fb_ord;
                end else begin
                    found = 1'b0;
                    pick  = '0;
                end

                if (found) begin
                    reason = REASON_SELECTED;
                end else if (n_lease) begin
                    reason = REASON_LEASE;
                end else begin
                    reason = REASON_NONE;
                end

                n_out_valid = 1'b1;
                n_out_data  = pick;
                n_out_user  = {reason, found};

                // list done: back to the start-of-list state
                n_first     = 1'b1;
                n_pend_free = 1'b0;
                n_order_ok  = 1'b1;
                n_ff_seen   = 1'b0;
                n_best_seen = 1'b0;
                n_min_span  = SPAN_FIRST;
                n_fb_seen   = 1'b0;
                n_lease     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= 1'b1;
            r_pend_free <= 1'b0;
            r_order_ok  <= 1'b1;
            r_ff_seen   <= 1'b0;
            r_best_seen <= 1'b0;
            r_fb_seen   <= 1'b0;
            r_lease     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_first     <= n_first;
            r_pend_free <= n_pend_free;
            r_order_ok  <= n_order_ok;
            r_ff_seen   <= n_ff_seen;
            r_best_seen <= n_best_seen;
            r_fb_seen   <= n_fb_seen;
            r_lease     <= n_lease;
            r_out_valid <= n_out_valid;
        end
        r_prior_tok  <= n_prior_tok;
        r_prior2_tok <= n_prior2_tok;
        r_pend_ord   <= n_pend_ord;
        r_pend_start <= n_pend_start;
        r_ff_ord     <= n_ff_ord;
        r_min_span   <= n_min_span;
        r_best_ord   <= n_best_ord;
        r_fb_ord     <= n_fb_ord;
        r_out_data   <= n_out_data;
        r_out_user   <= n_out_user;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cevs_checker.sv =====
// cevs_checker: port-level assertions for the victim selector
// depends on cevs_pkg; bound to checkpoint_eviction_victim_select_top below
`default_nettype none

module cevs_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_m_tvalid,
    input wire logic                            i_m_tready,
    input wire logic [cevs_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input wire logic [cevs_pkg::M_TUSER_W-1:0]  o_m_tuser
);
    import cevs_pkg::*;

    // stalled verdict holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("verdict changed while stalled");

    // found flag and reason agree
    a_found_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser[0] == (o_m_tuser[2:1] == REASON_SELECTED)))
        else $error("found flag disagrees with reason");

    // no victim means zero ordinal and a blocking reason
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |->
            o_m_tdata == '0 &&
            (o_m_tuser[2:1] == REASON_LEASE || o_m_tuser[2:1] == REASON_NONE))
        else $error("empty verdict carries ordinal or bad reason");

    // reset drops the verdict
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("verdict valid after reset");

endmodule

bind checkpoint_eviction_victim_select_top cevs_checker u_cevs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
